>>> src/fgb_pkg.sv
// ----------------------------------------------------------------------------
// fgb_pkg: shared types and constants for the group barrier
// Item structs, action and result codes, and widths used by the barrier
// and its slot table.
// ----------------------------------------------------------------------------
package fgb_pkg;

  localparam int SLOTS   = 16;
  localparam int ID_BITS = 16;
  localparam int GS_W    = 5;
  localparam int GEN_W   = 16;
  localparam int CODE_W  = 4;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int CMP_W   = ((CNT_W > GS_W) ? CNT_W : GS_W) + 1;

  // Input actions
  localparam logic [1:0] ACT_ARRIVE = 2'd0;
  localparam logic [1:0] ACT_WAKE   = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;
  localparam logic [1:0] ACT_RESET  = 2'd3;

  // Item kinds
  localparam logic KIND_REPLY   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Result codes
  localparam logic [CODE_W-1:0] CODE_NORMAL    = 4'd0;
  localparam logic [CODE_W-1:0] CODE_EARLY     = 4'd1;
  localparam logic [CODE_W-1:0] CODE_CANCELLED = 4'd2;
  localparam logic [CODE_W-1:0] CODE_BLOCKED   = 4'd3;
  localparam logic [CODE_W-1:0] CODE_TRIPPED   = 4'd4;
  localparam logic [CODE_W-1:0] CODE_REJECTED  = 4'd5;
  localparam logic [CODE_W-1:0] CODE_WAKE_OK   = 4'd6;
  localparam logic [CODE_W-1:0] CODE_WAKE_FAIL = 4'd7;
  localparam logic [CODE_W-1:0] CODE_DONE      = 4'd8;

  typedef struct packed {
    logic [1:0]         action;
    logic [ID_BITS-1:0] thread_id;
  } in_item_t;

  typedef struct packed {
    logic               item_kind;
    logic [ID_BITS-1:0] who;
    logic [CODE_W-1:0]  code;
    logic [GEN_W-1:0]   phase;
    logic               last;
  } out_item_t;

  // Write request into the slot table
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [ID_BITS-1:0] id;
  } slot_wr_t;

endpackage

>>> src/fgb_slot_table.sv
// ----------------------------------------------------------------------------
// fgb_slot_table: requester id store with one compare unit
// Holds the id owning each slot. The entry at the read address is registered
// every cycle and compared against the id being searched for, so the caller
// presents the address in the cycle before it examines that slot.
// ----------------------------------------------------------------------------
module fgb_slot_table
  import fgb_pkg::*;
(
  input  logic               clk,
  input  slot_wr_t           wr,
  input  logic [IDX_W-1:0]   rd_idx,
  input  logic [ID_BITS-1:0] key,
  output logic [ID_BITS-1:0] rd_owner,
  output logic               hit
);

  logic [ID_BITS-1:0] owner_mem [SLOTS];
  logic [ID_BITS-1:0] rd_owner_r;

  // Store the id of a newly registered requester
  always_ff @(posedge clk) begin
    if (wr.en) begin
      owner_mem[wr.addr] <= wr.id;
    end
  end

  // Register the entry at the read address
  always_ff @(posedge clk) begin
    rd_owner_r <= owner_mem[rd_idx];
  end

  // Compare the registered entry
  assign rd_owner = rd_owner_r;
  assign hit      = (rd_owner_r == key);

endmodule

>>> src/flexible_group_barrier.sv
// ----------------------------------------------------------------------------
// flexible_group_barrier: counting barrier with early release
// Command-style barrier: arrive, wake, cancel and reset requests each give
// one reply transaction followed by one release transaction per freed
// requester.
// ----------------------------------------------------------------------------
// Usage:
//   Input: present in_data with start high; it is taken at an edge where
//   busy is low. busy falls in the cycle that carries its last transaction.
//   Output: each transaction shows on out_data for one cycle with out_valid
//   high; the receiver cannot stall, so there is no backpressure.
//   Config: group_size is written through cfg_valid/cfg_ready/cfg_data,
//   taken only while the block is idle (cfg_ready = !busy).
// Timing:
//   Arrive and wake walk the registered slots with one id comparator, one
//   slot per cycle, until a hit or the end of the registered slots.
//   A decide cycle follows, and the reply is on out_data in the cycle after
//   it. Releases are scanned slot by slot up to the last waiter. A new
//   command is taken only when the block is back in idle.
// Reset:
//   rst_n low clears all waiters, counts, phase and the cancel flag, and
//   sets group_size to 16. Slot ids are left as they were.
// ----------------------------------------------------------------------------
module flexible_group_barrier
  import fgb_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  in_item_t        in_data,
  output logic            out_valid,
  output out_item_t       out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [GS_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_REL    = 5'b01000,
    S_WAKE   = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         act_r, act_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic [SLOTS-1:0]   waiting_r, waiting_nxt;
  logic [CNT_W-1:0]   reg_cnt_r, reg_cnt_nxt;
  logic [CNT_W-1:0]   wait_cnt_r, wait_cnt_nxt;
  logic [GEN_W-1:0]   gen_r, gen_nxt;
  logic               cancel_r, cancel_nxt;
  logic [GS_W-1:0]    group_size_r;
  logic [CODE_W-1:0]  rel_code_r, rel_code_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  slot_wr_t           slot_wr;
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic [ID_BITS-1:0] rd_owner;
  logic               hit;
  logic               slot_free;
  logic               trip;
  logic [IDX_W-1:0]   tgt;
  logic [SLOTS-1:0]   rel_rest;

  assign scan_idx = idx_r[IDX_W-1:0];

  // Address the table one step ahead so its registered read lines up with idx_r
  assign rd_idx   = idx_nxt[IDX_W-1:0];

  fgb_slot_table u_table (
    .clk      (clk),
    .wr       (slot_wr),
    .rd_idx   (rd_idx),
    .key      (id_r),
    .rd_owner (rd_owner),
    .hit      (hit)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new slot is free below both group_size and the table depth
  assign slot_free = (CMP_W'(reg_cnt_r) < CMP_W'(group_size_r)) &&
                     (CMP_W'(reg_cnt_r) < CMP_W'(SLOTS));
  assign trip      = (CMP_W'(wait_cnt_r) + CMP_W'(1)) >= CMP_W'(group_size_r);
  assign tgt       = found_r ? slot_r : reg_cnt_r[IDX_W-1:0];

  // Waiters left once the scanned slot is released
  always_comb begin
    rel_rest           = waiting_r;
    rel_rest[scan_idx] = 1'b0;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    id_nxt        = id_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    waiting_nxt   = waiting_r;
    reg_cnt_nxt   = reg_cnt_r;
    wait_cnt_nxt  = wait_cnt_r;
    gen_nxt       = gen_r;
    cancel_nxt    = cancel_r;
    rel_code_nxt  = rel_code_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    slot_wr       = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt   = in_data.action;
          id_nxt    = in_data.thread_id;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          if (in_data.action == ACT_ARRIVE || in_data.action == ACT_WAKE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end

      // Look up the id among registered slots
      S_SCAN: begin
        if (idx_r == reg_cnt_r) begin
          state_nxt = S_DECIDE;
        end else if (hit) begin
          found_nxt = 1'b1;
          slot_nxt  = scan_idx;
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      // Apply the request and issue the reply
      S_DECIDE: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.item_kind  = KIND_REPLY;
        out_data_nxt.who        = id_r;
        out_data_nxt.phase      = gen_r;
        out_data_nxt.last       = 1'b1;
        idx_nxt                 = '0;
        state_nxt               = S_IDLE;
        case (act_r)
          ACT_ARRIVE: begin
            if (cancel_r || (!found_r && !slot_free)) begin
              out_data_nxt.code = CODE_REJECTED;
            end else if (found_r && waiting_r[slot_r]) begin
              out_data_nxt.code = CODE_BLOCKED;
            end else begin
              if (!found_r) begin
                slot_wr.en   = 1'b1;
                slot_wr.addr = tgt;
                slot_wr.id   = id_r;
                reg_cnt_nxt  = reg_cnt_r + CNT_W'(1);
              end
              if (trip) begin
                gen_nxt            = gen_r + GEN_W'(1);
                wait_cnt_nxt       = '0;
                out_data_nxt.code  = CODE_TRIPPED;
                out_data_nxt.phase = gen_r + GEN_W'(1);
                rel_code_nxt       = CODE_NORMAL;
                if (|waiting_r) begin
                  out_data_nxt.last = 1'b0;
                  state_nxt         = S_REL;
                end
              end else begin
                waiting_nxt[tgt]  = 1'b1;
                wait_cnt_nxt      = wait_cnt_r + CNT_W'(1);
                out_data_nxt.code = CODE_BLOCKED;
              end
            end
          end
          ACT_WAKE: begin
            if (found_r && waiting_r[slot_r]) begin
              waiting_nxt[slot_r] = 1'b0;
              if (wait_cnt_r != '0) begin
                wait_cnt_nxt = wait_cnt_r - CNT_W'(1);
              end
              out_data_nxt.code = CODE_WAKE_OK;
              out_data_nxt.last = 1'b0;
              state_nxt         = S_WAKE;
            end else begin
              out_data_nxt.code = CODE_WAKE_FAIL;
            end
          end
          ACT_CANCEL: begin
            cancel_nxt        = 1'b1;
            wait_cnt_nxt      = '0;
            out_data_nxt.who  = '0;
            out_data_nxt.code = CODE_DONE;
            rel_code_nxt      = CODE_CANCELLED;
            if (|waiting_r) begin
              out_data_nxt.last = 1'b0;
              state_nxt         = S_REL;
            end
          end
          default: begin
            cancel_nxt         = 1'b0;
            gen_nxt            = gen_r + GEN_W'(1);
            wait_cnt_nxt       = '0;
            out_data_nxt.who   = '0;
            out_data_nxt.code  = CODE_DONE;
            out_data_nxt.phase = gen_r + GEN_W'(1);
            rel_code_nxt       = CODE_NORMAL;
            if (|waiting_r) begin
              out_data_nxt.last = 1'b0;
              state_nxt         = S_REL;
            end
          end
        endcase
      end

      // Walk the slots and release each waiter in slot order
      S_REL: begin
        if (waiting_r[scan_idx]) begin
          waiting_nxt[scan_idx]  = 1'b0;
          out_valid_nxt          = 1'b1;
          out_data_nxt.item_kind = KIND_RELEASE;
          out_data_nxt.who       = rd_owner;
          out_data_nxt.code      = rel_code_r;
          out_data_nxt.phase     = gen_r;
          out_data_nxt.last      = !(|rel_rest);
        end
        if (!(|rel_rest)) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      // Early release of the woken requester
      S_WAKE: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.item_kind = KIND_RELEASE;
        out_data_nxt.who       = id_r;
        out_data_nxt.code      = CODE_EARLY;
        out_data_nxt.phase     = gen_r;
        out_data_nxt.last      = 1'b1;
        state_nxt              = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      waiting_r    <= '0;
      reg_cnt_r    <= '0;
      wait_cnt_r   <= '0;
      gen_r        <= '0;
      cancel_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      group_size_r <= GS_W'(16);
    end else begin
      state_r     <= state_nxt;
      waiting_r   <= waiting_nxt;
      reg_cnt_r   <= reg_cnt_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
      gen_r       <= gen_nxt;
      cancel_r    <= cancel_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        group_size_r <= cfg_data;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    id_r       <= id_nxt;
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    slot_r     <= slot_nxt;
    rel_code_r <= rel_code_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
